// ----- design/tty_line_discipline_defines.svh -----
// Assertion macros for the checker file tty_chk.sv.
`ifndef TTY_LINE_DISCIPLINE_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TTY_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define TTY_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tty_pkg.sv -----
// ---------------------------------------------------------------------------
// tty_pkg
// Shared constants and types of the serial console line discipline.
// ---------------------------------------------------------------------------
package tty_pkg;

	localparam int unsigned LineBytesDef  = 64;
	localparam int unsigned QueueSlotsDef = 8;

	localparam logic [7:0] ChBs   = 8'h08;
	localparam logic [7:0] ChDel  = 8'h7f;
	localparam logic [7:0] ChKill = 8'h15;
	localparam logic [7:0] ChIntr = 8'h03;
	localparam logic [7:0] ChEof  = 8'h04;
	localparam logic [7:0] ChSp   = 8'h20;
	localparam logic [7:0] ChCr   = 8'h0d;
	localparam logic [7:0] ChLf   = 8'h0a;
	localparam logic [7:0] ChBell = 8'h07;

	localparam logic [23:0] TxtCrlf  = 24'h000a0d;
	localparam logic [23:0] TxtErase = 24'h082008;
	localparam logic [23:0] TxtIntr  = 24'h00435e;

	localparam logic [1:0] KindStatus = 2'd0;
	localparam logic [1:0] KindEcho   = 2'd1;
	localparam logic [1:0] KindData   = 2'd2;

	localparam logic OpRx   = 1'b0;
	localparam logic OpRead = 1'b1;

	localparam logic [1:0] RegCanonical = 2'd0;
	localparam logic [1:0] RegEchoOn    = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_ENQ_NL,
		ST_KILL,
		ST_RD_FETCH,
		ST_RD_WAIT,
		ST_RD_EMIT,
		ST_EMIT
	} state_t;

endpackage

// ----- design/tty_if.sv -----
// ---------------------------------------------------------------------------
// tty_in_if / tty_out_if
// Valid/ready channels carrying requests and results of the line discipline.
// ---------------------------------------------------------------------------
interface tty_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	logic [6:0] read_max;
	modport source (output valid, op, rx_byte, read_max, input ready);
	modport sink (input valid, op, rx_byte, read_max, output ready);
endinterface

interface tty_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [23:0] text;
	logic [1:0]  text_len;
	logic        last;
	logic        dropped;
	logic [2:0]  lines_pending;
	modport source (output valid, kind, text, text_len, last, dropped, lines_pending,
		input ready);
	modport sink (input valid, kind, text, text_len, last, dropped, lines_pending,
		output ready);
endinterface

// ----- design/tty_line_discipline.sv -----
// ---------------------------------------------------------------------------
// tty_line_discipline
// Canonical line editing and line queue for a serial console receiver.
// ---------------------------------------------------------------------------
// Usage: requests arrive on the in channel (received byte or read of one
// queued line) and results leave on the out channel, one or more per
// request, the final one marked by last. The user must write configuration
// over the APB port only while no request is in flight; the block does not
// enforce this. One request is handled at a time, and the next is taken
// only once the last result has left the output register. A plain edit
// passes through ST_DECODE and ST_EMIT before its result is registered. A
// line terminator copies the partial line into the queue memory one byte
// per cycle; with echo on, a kill walks one erase result per byte; a read
// emits each byte through ST_RD_WAIT and ST_RD_EMIT while the receiver
// takes them. The partial line memory and line store are single-port.
// Reset empties the partial line and the queue and sets canonical and echo
// mode; the memories are not cleared. When the receiver stalls, the current
// result is held in the output register and processing waits.
// ---------------------------------------------------------------------------
module tty_line_discipline
	import tty_pkg::*;
#(
	parameter int unsigned LINE_BYTES  = LineBytesDef,
	parameter int unsigned QUEUE_SLOTS = QueueSlotsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	tty_in_if.sink      in_ch,
	tty_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned LW = $clog2(LINE_BYTES);
	localparam int unsigned QW = $clog2(QUEUE_SLOTS);
	localparam logic [LW-1:0] LenMax = LW'(LINE_BYTES - 1);

	logic [7:0] pl_mem [LINE_BYTES];
	logic [7:0] ls_mem [QUEUE_SLOTS << LW];
	logic [LW:0] sl_mem [QUEUE_SLOTS];

	logic canonical_q, echo_on_q;
	state_t state_q, state_d;
	logic [LW-1:0] plen_q, plen_d;
	logic [QW-1:0] head_q, head_d, tail_q, tail_d;
	logic [LW:0] idx_q, idx_d, cnt_q, cnt_d;
	logic op_q;
	logic [7:0] byte_q;
	logic [6:0] rmax_q;
	logic drop_q, drop_d;
	logic [7:0] pl_rd_q, ls_rd_q;
	logic [LW:0] sl_rd_q;
	logic in_take;

	// Memory ports driven by the sequencer.
	logic pl_we, ls_we, sl_we;
	logic [LW-1:0] pl_addr, ls_off;
	logic [QW-1:0] ls_slot;
	logic [7:0] pl_wd, ls_wd;
	logic [LW:0] sl_wd;

	// Pending result register.
	logic ov_q, ov_d;
	logic [1:0] okind_q, okind_d, olen_q, olen_d;
	logic [23:0] otext_q, otext_d;
	logic olast_q, olast_d;

	logic [QW-1:0] tail_nx, head_nx;
	logic q_full, q_empty;
	logic [LW:0] rd_len;

	function automatic logic [QW-1:0] pend_next(input logic [QW-1:0] h, input logic [QW-1:0] t);
		pend_next = (t >= h) ? t - h : QW'(32'(t) + QUEUE_SLOTS - 32'(h));
	endfunction

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == RegEchoOn[0]) prdata[0] = echo_on_q;
		else                          prdata[0] = canonical_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canonical_q <= 1'b1;
			echo_on_q   <= 1'b1;
		end else if (psel && penable && pwrite) begin
			if (paddr == {RegCanonical[0], 2'b00}) canonical_q <= pwdata[0];
			if (paddr == {RegEchoOn[0], 2'b00})    echo_on_q   <= pwdata[0];
		end
	end

	always_ff @(posedge clk) begin
		if (pl_we) pl_mem[pl_addr] <= pl_wd;
		pl_rd_q <= pl_mem[pl_addr];
	end
	always_ff @(posedge clk) begin
		if (ls_we) ls_mem[{ls_slot, ls_off}] <= ls_wd;
		ls_rd_q <= ls_mem[{ls_slot, ls_off}];
	end
	always_ff @(posedge clk) begin
		if (sl_we) sl_mem[tail_q] <= sl_wd;
		sl_rd_q <= sl_mem[head_q];
	end

	assign tail_nx = (32'(tail_q) == QUEUE_SLOTS - 1) ? '0 : tail_q + 1'b1;
	assign head_nx = (32'(head_q) == QUEUE_SLOTS - 1) ? '0 : head_q + 1'b1;
	assign q_full  = (tail_nx == head_q);
	assign q_empty = (tail_q == head_q);
	assign rd_len  = (rmax_q < 7'(sl_rd_q)) ? (LW+1)'(rmax_q) : sl_rd_q;

	// A new request waits until the previous result has left.
	assign in_ch.ready = (state_q == ST_IDLE) && !ov_q;
	assign in_take = in_ch.valid && in_ch.ready;

	always_comb begin
		state_d = state_q; plen_d = plen_q; head_d = head_q; tail_d = tail_q;
		idx_d = idx_q; cnt_d = cnt_q; drop_d = drop_q;
		ov_d = ov_q; okind_d = okind_q; otext_d = otext_q; olen_d = olen_q;
		olast_d = olast_q;
		pl_we = 1'b0; pl_addr = plen_q; pl_wd = byte_q;
		ls_we = 1'b0; ls_slot = tail_q; ls_off = idx_q[LW-1:0]; ls_wd = pl_rd_q;
		sl_we = 1'b0; sl_wd = idx_q + 1'b1;
		if (ov_q && out_ch.ready) ov_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					drop_d = 1'b0;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				idx_d = '0;
				okind_d = KindStatus; otext_d = '0; olen_d = 2'd0; olast_d = 1'b1;
				state_d = ST_EMIT;
				if (op_q == OpRead) begin
					if (q_empty) state_d = ST_EMIT;
					else state_d = ST_RD_FETCH;
				end else if (!canonical_q) begin
					if (q_full) drop_d = 1'b1;
					else begin
						ls_we = 1'b1; ls_off = '0; ls_wd = byte_q;
						idx_d = (LW+1)'(1);
						state_d = ST_ENQ_NL;
					end
				end else if (byte_q == ChCr || byte_q == ChLf) begin
					if (echo_on_q) begin
						okind_d = KindEcho; otext_d = TxtCrlf; olen_d = 2'd2;
					end
					cnt_d = (LW+1)'(plen_q);
					plen_d = '0;
					if (q_full) drop_d = 1'b1;
					else state_d = (plen_q == '0) ? ST_ENQ_NL : ST_COPY_RD;
				end else if (byte_q == ChEof) begin
					cnt_d = (LW+1)'(plen_q);
					plen_d = '0;
					if (q_full) drop_d = 1'b1;
					else state_d = (plen_q == '0) ? ST_ENQ_NL : ST_COPY_RD;
				end else if (byte_q == ChBs || byte_q == ChDel) begin
					if (plen_q != '0) begin
						plen_d = plen_q - 1'b1;
						if (echo_on_q) begin
							okind_d = KindEcho; otext_d = TxtErase; olen_d = 2'd3;
						end
					end
				end else if (byte_q == ChKill) begin
					if (plen_q != '0 && echo_on_q) state_d = ST_KILL;
					plen_d = '0;
					if (echo_on_q) plen_d = plen_q;
				end else if (byte_q == ChIntr) begin
					plen_d = '0;
					if (echo_on_q) begin
						okind_d = KindEcho; otext_d = TxtIntr; olen_d = 2'd2;
					end
				end else if (byte_q >= ChSp && byte_q < ChDel) begin
					if (plen_q < LenMax) begin
						pl_we = 1'b1;
						plen_d = plen_q + 1'b1;
						if (echo_on_q) begin
							okind_d = KindEcho; otext_d = {16'h0, byte_q}; olen_d = 2'd1;
						end
					end else begin
						drop_d = 1'b1;
						if (echo_on_q) begin
							okind_d = KindEcho; otext_d = {16'h0, ChBell}; olen_d = 2'd1;
						end
					end
				end
			end
			ST_COPY_RD: begin
				// Read one partial line byte; it is written to the slot next cycle.
				pl_addr = idx_q[LW-1:0];
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				ls_we = 1'b1;
				idx_d = idx_q + 1'b1;
				pl_addr = idx_q[LW-1:0] + 1'b1;
				if (idx_q + 1'b1 == cnt_q) state_d = ST_ENQ_NL;
				else state_d = ST_COPY_WR;
			end
			ST_ENQ_NL: begin
				ls_we = 1'b1; ls_wd = ChLf;
				sl_we = 1'b1;
				tail_d = tail_nx;
				state_d = ST_EMIT;
			end
			ST_KILL: begin
				if (!ov_q || out_ch.ready) begin
					ov_d = 1'b1;
					okind_d = KindEcho; otext_d = TxtErase; olen_d = 2'd3;
					olast_d = (plen_q == LW'(1));
					plen_d = plen_q - 1'b1;
					if (plen_q == LW'(1)) state_d = ST_IDLE;
				end
			end
			ST_RD_FETCH: begin
				// sl_rd_q is valid now; start the first byte read.
				ls_slot = head_q; ls_off = '0;
				if (rd_len == '0) begin
					head_d = head_nx;
					state_d = ST_EMIT;
				end else state_d = ST_RD_WAIT;
			end
			ST_RD_WAIT: begin
				ls_slot = head_q; ls_off = idx_q[LW-1:0];
				state_d = ST_RD_EMIT;
			end
			ST_RD_EMIT: begin
				ls_slot = head_q; ls_off = idx_q[LW-1:0];
				if (!ov_q || out_ch.ready) begin
					ov_d = 1'b1;
					okind_d = KindData; otext_d = {16'h0, ls_rd_q}; olen_d = 2'd1;
					olast_d = (idx_q + 1'b1 == rd_len);
					idx_d = idx_q + 1'b1;
					if (idx_q + 1'b1 == rd_len) begin
						head_d = head_nx;
						state_d = ST_IDLE;
					end else state_d = ST_RD_WAIT;
				end
			end
			ST_EMIT: begin
				if (!ov_q || out_ch.ready) begin
					ov_d = 1'b1;
					olast_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plen_q <= '0; head_q <= '0; tail_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			plen_q <= plen_d; head_q <= head_d; tail_q <= tail_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d; cnt_q <= cnt_d; drop_q <= drop_d;
		okind_q <= okind_d; otext_q <= otext_d; olen_q <= olen_d; olast_q <= olast_d;
		if (in_take) begin
			op_q <= in_ch.op; byte_q <= in_ch.rx_byte; rmax_q <= in_ch.read_max;
		end
	end

	// Every result of a read already counts the head line as removed.
	logic [2:0] pend_q;
	always_ff @(posedge clk) begin
		if (!ov_q || out_ch.ready)
			pend_q <= 3'(pend_next((state_q == ST_RD_EMIT) ? head_nx : head_d, tail_d));
	end

	logic dropo_q;
	always_ff @(posedge clk) begin
		if (!ov_q || out_ch.ready) dropo_q <= drop_d;
	end

	assign out_ch.valid = ov_q;
	assign out_ch.kind = okind_q;
	assign out_ch.text = otext_q;
	assign out_ch.text_len = olen_q;
	assign out_ch.last = olast_q;
	assign out_ch.dropped = dropo_q;
	assign out_ch.lines_pending = pend_q;

endmodule

// ----- design/tty_chk.sv -----
// ---------------------------------------------------------------------------
// tty_chk
// Port-level checks of the line discipline, bound into tty_line_discipline.
// ---------------------------------------------------------------------------
`include "tty_line_discipline_defines.svh"

module tty_chk
	import tty_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_last,
	input logic [1:0] out_kind,
	input logic [1:0] out_text_len
);

	`TTY_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`TTY_ASSERT_IMPL(a_kind, clk, arst_n, out_valid, out_kind <= KindData, "bad kind")
	`TTY_ASSERT_IMPL(a_data_len, clk, arst_n, out_valid && out_kind == KindData,
		out_text_len == 2'd1, "data result length")
	`TTY_ASSERT_IMPL(a_status_len, clk, arst_n, out_valid && out_kind == KindStatus,
		out_text_len == 2'd0 && out_last, "status result")
	`TTY_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "took two items")

endmodule

bind tty_line_discipline tty_chk u_tty_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.last), .out_kind(out_ch.kind), .out_text_len(out_ch.text_len)
);

// ----- tb/sv/tty_line_discipline_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tty_line_discipline_tb
// Self-checking bench for the serial console line discipline. Requests go in
// through a clocked driver fed from a queue, and results are compared field
// by field against an in-bench model of line editing and the line queue.
// ---------------------------------------------------------------------------
module tty_line_discipline_tb;
	import tty_pkg::*;

	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned Slots      = QueueSlotsDef;
	localparam int unsigned LineMax    = LineBytesDef;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic [6:0] read_max;
	} tty_req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] text;
		logic [1:0]  text_len;
		logic        last;
		logic        dropped;
		logic [2:0]  lines_pending;
	} tty_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tty_in_if  in_if ();
	tty_out_if out_if ();

	tty_line_discipline u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_if),
		.out_ch  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tty_req_t    req_q[$];
	tty_res_t    result_q[$];
	int unsigned send_idle;
	int unsigned recv_idle;
	int unsigned fail_count;
	int unsigned cycle_count;

	// Model state of the line discipline.
	logic [7:0]  line_buf[LineMax];
	int unsigned line_len;
	logic [7:0]  store[Slots][LineMax];
	int unsigned store_len[Slots];
	int unsigned head;
	int unsigned tail;
	logic        mode_canon;
	logic        mode_echo;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic bit queue_line();
		int unsigned n;
		if ((tail + 1) % Slots == head)
			return 1'b1;
		n = (line_len > LineMax - 1) ? LineMax - 1 : line_len;
		for (int unsigned i = 0; i < n; i++)
			store[tail][i] = line_buf[i];
		store[tail][n] = ChLf;
		store_len[tail] = n + 1;
		tail = (tail + 1) % Slots;
		return 1'b0;
	endfunction

	function automatic void add_echo(ref tty_res_t res[$], input logic [1:0] kind,
			input logic [23:0] text, input logic [1:0] len);
		tty_res_t r;
		r = '0;
		r.kind = kind;
		r.text = text;
		r.text_len = len;
		res.push_back(r);
	endfunction

	// Applies one accepted request to the model and queues the results it causes.
	function automatic void predict_edit(tty_req_t req);
		tty_res_t    res[$];
		bit          drop;
		int unsigned n;
		logic [7:0]  b;
		logic [7:0]  keep_b;
		int unsigned keep_len;
		drop = 1'b0;
		b = req.rx_byte;
		if (req.op == OpRead) begin
			if (head != tail) begin
				n = store_len[head];
				if (n > req.read_max)
					n = req.read_max;
				for (int unsigned i = 0; i < n; i++)
					add_echo(res, KindData, {16'h0, store[head][i]}, 2'd1);
				head = (head + 1) % Slots;
			end
		end else if (!mode_canon) begin
			// Raw bytes leave the partial line untouched.
			keep_b = line_buf[0];
			keep_len = line_len;
			line_buf[0] = b;
			line_len = 1;
			drop = queue_line();
			line_buf[0] = keep_b;
			line_len = keep_len;
		end else if (b == ChCr || b == ChLf) begin
			if (mode_echo)
				add_echo(res, KindEcho, TxtCrlf, 2'd2);
			drop = queue_line();
			line_len = 0;
		end else if (b == ChBs || b == ChDel) begin
			if (line_len > 0) begin
				line_len--;
				if (mode_echo)
					add_echo(res, KindEcho, TxtErase, 2'd3);
			end
		end else if (b == ChKill) begin
			while (line_len > 0) begin
				if (mode_echo)
					add_echo(res, KindEcho, TxtErase, 2'd3);
				line_len--;
			end
		end else if (b == ChIntr) begin
			line_len = 0;
			if (mode_echo)
				add_echo(res, KindEcho, TxtIntr, 2'd2);
		end else if (b == ChEof) begin
			drop = queue_line();
			line_len = 0;
		end else if (b >= ChSp && b < ChDel) begin
			if (line_len < LineMax - 1) begin
				line_buf[line_len] = b;
				line_len++;
				if (mode_echo)
					add_echo(res, KindEcho, {16'h0, b}, 2'd1);
			end else begin
				if (mode_echo)
					add_echo(res, KindEcho, {16'h0, ChBell}, 2'd1);
				drop = 1'b1;
			end
		end
		if (res.size() == 0)
			add_echo(res, KindStatus, 24'h0, 2'd0);
		foreach (res[k]) begin
			res[k].last = (k == res.size() - 1);
			res[k].dropped = drop;
			res[k].lines_pending = 3'((tail + Slots - head) % Slots);
			result_q.push_back(res[k]);
		end
	endfunction

	function automatic void push_req(logic op, logic [7:0] b, logic [6:0] rmax);
		tty_req_t r;
		r.op = op;
		r.rx_byte = b;
		r.read_max = rmax;
		req_q.push_back(r);
	endfunction

	function automatic void push_byte(logic [7:0] b);
		push_req(OpRx, b, 7'($urandom_range(0, 64)));
	endfunction

	// Mostly whole lines with random content and edits, with reads and noise between.
	function automatic void add_traffic(int unsigned count);
		int unsigned added;
		int unsigned len;
		int unsigned pick;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(99);
			if (pick < 14) begin
				push_req(OpRead, 8'($urandom), ($urandom_range(5) == 0) ? 7'd64 :
					7'($urandom_range(0, 64)));
				added++;
			end else if (pick < 20) begin
				push_byte(8'($urandom_range(0, 255)));
				added++;
			end else begin
				len = ($urandom_range(9) == 0) ? $urandom_range(58, 68) : $urandom_range(0, 10);
				for (int unsigned i = 0; i < len; i++) begin
					pick = $urandom_range(99);
					if (pick < 8)
						push_byte(($urandom_range(1) == 0) ? ChBs : ChDel);
					else if (pick < 10)
						push_byte(ChKill);
					else
						push_byte(8'($urandom_range(32, 126)));
				end
				case ($urandom_range(5))
					0: push_byte(ChLf);
					1: push_byte(ChEof);
					2: push_byte(ChIntr);
					default: push_byte(ChCr);
				endcase
				added += len + 1;
			end
		end
	endfunction

	// Driver: predicts each accepted request and offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.op <= OpRx;
			in_if.rx_byte <= 8'h0;
			in_if.read_max <= 7'h0;
		end else begin
			if (in_if.valid && in_if.ready)
				predict_edit('{in_if.op, in_if.rx_byte, in_if.read_max});
			if (!in_if.valid || in_if.ready) begin
				if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_if.op <= req_q[0].op;
					in_if.rx_byte <= req_q[0].rx_byte;
					in_if.read_max <= req_q[0].read_max;
					in_if.valid <= 1'b1;
					void'(req_q.pop_front());
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stalls the result channel at random and checks each transaction.
	always @(posedge clk or negedge arst_n) begin
		tty_res_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result transaction, kind %0d", out_if.kind);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (out_if.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, out_if.kind);
						fail_count++;
					end
					if (out_if.text !== want.text) begin
						$error("text: expected %h, got %h", want.text, out_if.text);
						fail_count++;
					end
					if (out_if.text_len !== want.text_len) begin
						$error("text_len: expected %0d, got %0d", want.text_len, out_if.text_len);
						fail_count++;
					end
					if (out_if.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_if.last);
						fail_count++;
					end
					if (out_if.dropped !== want.dropped) begin
						$error("dropped: expected %0d, got %0d", want.dropped, out_if.dropped);
						fail_count++;
					end
					if (out_if.lines_pending !== want.lines_pending) begin
						$error("lines_pending: expected %0d, got %0d", want.lines_pending,
							out_if.lines_pending);
						fail_count++;
					end
				end
			end
			out_if.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tty_line_discipline test failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (req_q.size() > 0 || in_if.valid || result_q.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 1'b0} << 1;
		pwdata <= {31'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == RegCanonical)
			mode_canon = value;
		else
			mode_echo = value;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycle_count = 0;
		fail_count = 0;
		line_len = 0;
		head = 0;
		tail = 0;
		mode_canon = 1'b1;
		mode_echo = 1'b1;
		send_idle = 31;
		recv_idle = 74;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Edits at the field extremes, every control byte and reads with read_max of 64, 0 and 1.
		push_byte(ChSp);
		push_byte(8'h7e);
		push_byte("a");
		push_byte(ChBs);
		push_byte(ChDel);
		push_byte(ChBs);
		push_byte(ChBs);
		push_byte("x");
		push_byte("y");
		push_byte(ChKill);
		push_byte("q");
		push_byte(ChIntr);
		push_byte(8'h01);
		push_byte(8'hff);
		push_byte(8'h80);
		push_byte("h");
		push_byte("i");
		push_byte(ChCr);
		push_byte(ChEof);
		push_byte(ChLf);
		push_req(OpRead, 8'h00, 7'd64);
		push_req(OpRead, 8'hff, 7'd0);
		push_req(OpRead, 8'h00, 7'd1);
		push_req(OpRead, 8'h00, 7'd64);
		add_traffic(60);
		wait_drained();

		write_reg(RegEchoOn, 1'b0);
		add_traffic(50);
		wait_drained();

		send_idle = 74;
		recv_idle = 31;
		write_reg(RegCanonical, 1'b0);
		add_traffic(50);
		wait_drained();

		write_reg(RegEchoOn, 1'b1);
		add_traffic(40);
		wait_drained();

		write_reg(RegCanonical, 1'b1);
		add_traffic(50);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		add_traffic(70);
		wait_drained();

		if (fail_count == 0)
			$display("tty_line_discipline test passed");
		else
			$display("tty_line_discipline test failed");
		$finish;
	end

endmodule
